/* rtl/core/pcs_pkg.sv */
// Package for the saturating PID controller: payload and register types,
// control word layout and the sequencer program.
// No dependencies.
`default_nettype none

package pcs_pkg;

    localparam int ErrW   = 17;
    localparam int IntegW = 32;
    localparam int MulAW  = 35;
    localparam int MulBW  = 17;
    localparam int ProdW  = MulAW + MulBW;
    localparam int AccW   = ProdW + 1;
    localparam int FracW  = 24;
    localparam int QW     = AccW - FracW;
    localparam int StepW  = 3;

    typedef struct packed {
        logic [15:0] measured;
        logic [15:0] setpoint;
    } pcs_in_t;

    typedef struct packed {
        logic [15:0] drive;
        logic        clamped;
    } pcs_out_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] int_gain;
        logic [15:0] deriv_gain;
        logic [15:0] step_time;
        logic [15:0] step_rate;
        logic [14:0] out_limit;
    } pcs_cfg_t;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INT_GAIN   = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_STEP_TIME  = 3'd3,
        CFG_STEP_RATE  = 3'd4,
        CFG_OUT_LIMIT  = 3'd5
    } pcs_cfg_idx_t;

    typedef enum logic [2:0] {
        ASEL_SUM,
        ASEL_DIFF,
        ASEL_PROD,
        ASEL_INTEG,
        ASEL_ERR
    } pcs_asel_t;

    typedef enum logic [2:0] {
        BSEL_TIME,
        BSEL_RATE,
        BSEL_KD,
        BSEL_KI,
        BSEL_KP
    } pcs_bsel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SH8
    } pcs_acc_op_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } pcs_jump_t;

    typedef logic [StepW-1:0] pcs_step_t;

    typedef struct packed {
        pcs_jump_t   jump;
        pcs_asel_t   asel;
        pcs_bsel_t   bsel;
        logic        mul_en;
        pcs_acc_op_t acc_op;
        logic        integ_we;
        logic        prev_we;
        logic        err_we;
        logic        out_we;
    } pcs_uword_t;

    // The last step falls through to step zero when the counter wraps.
    function automatic pcs_uword_t pcs_ucode(input pcs_step_t step);
        pcs_uword_t uw;
        uw        = '0;
        uw.jump   = JMP_NEXT;
        uw.asel   = ASEL_SUM;
        uw.bsel   = BSEL_TIME;
        uw.acc_op = ACC_HOLD;
        case (step)
            3'd0: begin
                uw.jump   = JMP_WAIT_IN;
                uw.err_we = 1'b1;
            end
            3'd1: begin
                uw.asel   = ASEL_SUM;
                uw.bsel   = BSEL_TIME;
                uw.mul_en = 1'b1;
            end
            3'd2: begin
                uw.integ_we = 1'b1;
                uw.asel     = ASEL_DIFF;
                uw.bsel     = BSEL_RATE;
                uw.mul_en   = 1'b1;
            end
            3'd3: begin
                uw.prev_we = 1'b1;
                uw.asel    = ASEL_PROD;
                uw.bsel    = BSEL_KD;
                uw.mul_en  = 1'b1;
            end
            3'd4: begin
                uw.acc_op = ACC_LOAD;
                uw.asel   = ASEL_INTEG;
                uw.bsel   = BSEL_KI;
                uw.mul_en = 1'b1;
            end
            3'd5: begin
                uw.acc_op = ACC_ADD;
                uw.asel   = ASEL_ERR;
                uw.bsel   = BSEL_KP;
                uw.mul_en = 1'b1;
            end
            3'd6: begin
                uw.acc_op = ACC_ADD_SH8;
            end
            3'd7: begin
                uw.jump   = JMP_WAIT_OUT;
                uw.out_we = 1'b1;
            end
            default: begin
                uw.jump = JMP_NEXT;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pcs_datapath.sv */
// Datapath of the saturating PID controller: one shared multiplier, the
// integral and error state, the accumulator and the result register.
// Depends on pcs_pkg.
`default_nettype none

module pcs_datapath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pcs_pkg::pcs_uword_t ctl,
    input  wire pcs_pkg::pcs_cfg_t   cfg,
    input  wire pcs_pkg::pcs_in_t    in_word,
    output pcs_pkg::pcs_out_t        out_word
);
    import pcs_pkg::*;

    logic signed [ErrW-1:0]   err_reg, err_next;
    logic signed [ErrW-1:0]   prev_reg, prev_next;
    logic signed [IntegW-1:0] integ_reg, integ_next;
    logic signed [ProdW-1:0]  prod_reg, prod_next;
    logic signed [AccW-1:0]   acc_reg, acc_next;
    pcs_out_t                 out_reg, out_next;

    logic signed [ErrW:0]     err_sum;
    logic signed [ErrW:0]     err_diff;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [ProdW-9:0]  integ_inc;
    logic signed [IntegW:0]   integ_wide;
    logic signed [QW-1:0]     q_floor;
    logic signed [QW-1:0]     q_val;
    logic signed [QW-1:0]     q_lim;
    logic                     round_up;

    assign err_sum  = (ErrW+1)'(err_reg) + (ErrW+1)'(prev_reg);
    assign err_diff = (ErrW+1)'(err_reg) - (ErrW+1)'(prev_reg);

    always_comb begin
        case (ctl.asel)
            ASEL_SUM:   mul_a = MulAW'(err_sum);
            ASEL_DIFF:  mul_a = MulAW'(err_diff);
            ASEL_PROD:  mul_a = $signed(prod_reg[MulAW-1:0]);
            ASEL_INTEG: mul_a = MulAW'(integ_reg);
            ASEL_ERR:   mul_a = MulAW'(err_reg);
            default:    mul_a = '0;
        endcase
        case (ctl.bsel)
            BSEL_TIME: mul_b = $signed({1'b0, cfg.step_time});
            BSEL_RATE: mul_b = $signed({1'b0, cfg.step_rate});
            BSEL_KD:   mul_b = MulBW'($signed(cfg.deriv_gain));
            BSEL_KI:   mul_b = MulBW'($signed(cfg.int_gain));
            BSEL_KP:   mul_b = MulBW'($signed(cfg.prop_gain));
            default:   mul_b = '0;
        endcase
    end

    always_comb begin
        err_next  = err_reg;
        prev_next = prev_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctl.err_we) begin
            err_next = ErrW'($signed(in_word.setpoint)) - ErrW'($signed(in_word.measured));
        end
        if (ctl.prev_we) begin
            prev_next = err_reg;
        end
        if (ctl.mul_en) begin
            prod_next = mul_a * mul_b;
        end
        case (ctl.acc_op)
            ACC_LOAD:    acc_next = AccW'(prod_reg);
            ACC_ADD:     acc_next = acc_reg + AccW'(prod_reg);
            ACC_ADD_SH8: acc_next = acc_reg + (AccW'(prod_reg) <<< 8);
            default:     acc_next = acc_reg;
        endcase
    end

    // Floor of the increment is an arithmetic shift; the sum saturates to 32 bits.
    assign integ_inc  = prod_reg[ProdW-1:8];
    assign integ_wide = (IntegW+1)'(integ_reg) + (IntegW+1)'(integ_inc);

    always_comb begin
        integ_next = integ_reg;
        if (ctl.integ_we) begin
            if (integ_wide[IntegW] != integ_wide[IntegW-1]) begin
                integ_next = integ_wide[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                                : {1'b0, {(IntegW-1){1'b1}}};
            end else begin
                integ_next = integ_wide[IntegW-1:0];
            end
        end
    end

    // Truncation toward zero: a negative sum with a nonzero fraction rounds up.
    assign q_floor  = acc_reg[AccW-1:FracW];
    assign round_up = acc_reg[AccW-1] && (|acc_reg[FracW-1:0]);
    assign q_val    = q_floor + QW'(round_up);
    assign q_lim    = $signed(QW'(cfg.out_limit));

    always_comb begin
        out_next = out_reg;
        if (ctl.out_we) begin
            if (q_val > q_lim) begin
                out_next.drive   = {1'b0, cfg.out_limit};
                out_next.clamped = 1'b1;
            end else if (q_val < -q_lim) begin
                out_next.drive   = -{1'b0, cfg.out_limit};
                out_next.clamped = 1'b1;
            end else begin
                out_next.drive   = q_val[15:0];
                out_next.clamped = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            integ_reg <= '0;
        end else begin
            prev_reg  <= prev_next;
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg  <= err_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign out_word = out_reg;

endmodule

`default_nettype wire

/* rtl/core/pid_controller_saturating_unit.sv */
// Top level of the saturating PID controller: handshakes, configuration
// registers and the microcoded step sequencer.
// Depends on pcs_pkg and pcs_datapath.
//
//   Channel   Ports                                 Direction  Word
//   input     s_valid, s_ready, s_data              in         measured, setpoint
//   result    m_valid, m_ready, m_data              out        drive, clamped
//   config    cfg_valid, cfg_ready, cfg_index/data  in         register index, value
//
// Each word runs the step that takes it in, five multiply steps on a single shared
// 35x17 multiplier, one add step and a last step that loads the result register.
// s_ready is high only on the program's first step.
// A result waiting on m_ready stalls the program at its last step only;
// the next input word is taken as soon as that result is registered.
// Reset (aresetn low, synchronous) clears the step, m_valid, integral and
// previous-error registers and loads register defaults.
`default_nettype none

module pid_controller_saturating_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pcs_pkg::pcs_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pcs_pkg::pcs_out_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import pcs_pkg::*;

    pcs_step_t  step_reg, step_next;
    logic       m_valid_reg, m_valid_next;
    pcs_cfg_t   cfg_reg, cfg_next;
    pcs_uword_t uw;
    pcs_uword_t ctl;
    logic       in_fire;
    logic       out_free;
    logic       advance;

    assign uw        = pcs_ucode(step_reg);
    assign s_ready   = (uw.jump == JMP_WAIT_IN);
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        case (uw.jump)
            JMP_WAIT_IN:  advance = in_fire;
            JMP_WAIT_OUT: advance = out_free;
            default:      advance = 1'b1;
        endcase
    end

    always_comb begin
        ctl        = uw;
        ctl.err_we = uw.err_we && in_fire;
        ctl.out_we = uw.out_we && out_free;
    end

    assign step_next = advance ? step_reg + 1'b1 : step_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.out_we) begin
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PROP_GAIN:  cfg_next.prop_gain  = cfg_data;
                CFG_INT_GAIN:   cfg_next.int_gain   = cfg_data;
                CFG_DERIV_GAIN: cfg_next.deriv_gain = cfg_data;
                CFG_STEP_TIME:  cfg_next.step_time  = cfg_data;
                CFG_STEP_RATE:  cfg_next.step_rate  = cfg_data;
                CFG_OUT_LIMIT:  cfg_next.out_limit  = cfg_data[14:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            cfg_reg     <= '{prop_gain:  16'd256,
                             int_gain:   16'd256,
                             deriv_gain: 16'd256,
                             step_time:  16'd13107,
                             step_rate:  16'd1280,
                             out_limit:  15'd400};
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    pcs_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .in_word  (s_data),
        .out_word (m_data)
    );

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for pid_controller_saturating_unit: random and directed samples
// checked word by word against a predictor of the clamped PID drive output.
// Depends on pcs_pkg and the RTL of the controller.
`timescale 1ns / 1ps

module tb;
    import pcs_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 200;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 118;
    localparam int SETTLE_CYCLES   = 20;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam int MODE_UNIFORM   = 0;
    localparam int MODE_PUSH_UP   = 1;
    localparam int MODE_PUSH_DOWN = 2;
    localparam int MODE_TRACK     = 3;
    localparam int MODE_CORNER    = 4;

    localparam longint INTEG_MAX = 64'sd2147483647;
    localparam longint INTEG_MIN = -64'sd2147483648;

    class drive_predictor;
        pcs_cfg_t           regs;
        logic signed [31:0] integ_acc;
        logic signed [16:0] last_err;
        pcs_out_t           expected_drive[$];
        int                 mismatches;

        function new();
            regs.prop_gain  = 16'd256;
            regs.int_gain   = 16'd256;
            regs.deriv_gain = 16'd256;
            regs.step_time  = 16'd13107;
            regs.step_rate  = 16'd1280;
            regs.out_limit  = 15'd400;
            integ_acc       = '0;
            last_err        = '0;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_PROP_GAIN:  regs.prop_gain  = data;
                CFG_INT_GAIN:   regs.int_gain   = data;
                CFG_DERIV_GAIN: regs.deriv_gain = data;
                CFG_STEP_TIME:  regs.step_time  = data;
                CFG_STEP_RATE:  regs.step_rate  = data;
                CFG_OUT_LIMIT:  regs.out_limit  = data[14:0];
                default: ;
            endcase
        endfunction

        function void note_sample(pcs_in_t w);
            longint   err, integ, deriv, acc, val, lim;
            pcs_out_t r;
            err   = longint'($signed(w.setpoint)) - longint'($signed(w.measured));
            integ = longint'(integ_acc)
                  + (((err + longint'(last_err)) * longint'(regs.step_time)) >>> 8);
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            if (integ < INTEG_MIN) integ = INTEG_MIN;
            integ_acc = integ[31:0];
            deriv     = (err - longint'(last_err)) * longint'(regs.step_rate);
            last_err  = err[16:0];
            acc = longint'($signed(regs.prop_gain)) * err * 256
                + longint'($signed(regs.int_gain)) * integ
                + longint'($signed(regs.deriv_gain)) * deriv;
            val = acc / (64'sd1 << 24);
            lim = longint'(regs.out_limit);
            r.clamped = 1'b0;
            if (val > lim) begin
                val       = lim;
                r.clamped = 1'b1;
            end else if (-val > lim) begin
                val       = -lim;
                r.clamped = 1'b1;
            end
            r.drive = val[15:0];
            expected_drive.push_back(r);
        endfunction

        function void check_drive(pcs_out_t got);
            pcs_out_t want;
            if (expected_drive.size() == 0) begin
                $error("result word with no sample pending: drive %0d clamped %0b",
                       $signed(got.drive), got.clamped);
                mismatches++;
                return;
            end
            want = expected_drive.pop_front();
            if (got.drive !== want.drive) begin
                $error("drive: expected %0d, got %0d", $signed(want.drive),
                       $signed(got.drive));
                mismatches++;
            end
            if (got.clamped !== want.clamped) begin
                $error("clamped: expected %0b, got %0b", want.clamped, got.clamped);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pcs_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    pcs_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    drive_predictor sb;
    bit             hold_req;
    int             stall_count;

    pid_controller_saturating_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
            1: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_data);
            if (m_valid && m_ready) sb.check_drive(m_data);
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count == STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int run;
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                              : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end else begin
                gap = idle_pick();
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    task automatic send_sample(input logic [15:0] measured, input logic [15:0] setpoint,
                               input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{measured: measured, setpoint: setpoint};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] dt,
                             input logic [15:0] rate, input logic [15:0] lim);
        write_register(CFG_PROP_GAIN, kp);
        write_register(CFG_INT_GAIN, ki);
        write_register(CFG_DERIV_GAIN, kd);
        write_register(CFG_STEP_TIME, dt);
        write_register(CFG_STEP_RATE, rate);
        write_register(CFG_OUT_LIMIT, lim);
        write_register(($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                       16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int          p;
        int          n;
        int          mode;
        int          run_left;
        logic        quiet;
        logic [15:0] anchor;
        logic [15:0] corner_vals[5];
        pcs_in_t     w;

        corner_vals = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        sb          = new();
        hold_req    = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(16'h0000, 16'h0000, idle_pick());
        send_sample(16'h8000, 16'h7FFF, idle_pick());
        send_sample(16'h7FFF, 16'h8000, idle_pick());
        send_sample(16'h7FFF, 16'h7FFF, idle_pick());
        send_sample(16'h8000, 16'h8000, idle_pick());
        send_sample(16'h0001, 16'h0000, idle_pick());
        send_sample(16'h0000, 16'h0001, idle_pick());
        send_sample(16'h5555, 16'hAAAA, idle_pick());
        send_sample(16'hAAAA, 16'h5555, idle_pick());
        drain_results();

        // With only a 2.0 proportional gain the drive is error / 128, which
        // lands exactly on the limit, just past it, and truncates toward zero.
        set_gains(16'h0200, 16'h0000, 16'h0000, 16'd13107, 16'd1280, 16'd400);
        send_sample(-16'sd25600, 16'sd25600, idle_pick());
        send_sample(16'sd25600, -16'sd25600, idle_pick());
        send_sample(-16'sd25728, 16'sd25728, idle_pick());
        send_sample(16'sd25728, -16'sd25728, idle_pick());
        send_sample(16'sd0, 16'sd127, idle_pick());
        send_sample(16'sd0, -16'sd127, idle_pick());
        drain_results();
        write_register(CFG_OUT_LIMIT, 16'h0000);
        write_register(CFG_SPARE_LO, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_sample(16'h0000, 16'h0000, idle_pick());
        send_sample(16'h0000, 16'h0080, idle_pick());

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: set_gains(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_gains(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
                2: set_gains(16'd64, 16'd2, 16'hFFE0, 16'($urandom_range(1, 65535)),
                             16'($urandom_range(1, 4096)), 16'h7FFF);
                default: set_gains(pick_gain(), pick_gain(), pick_gain(), pick_step(),
                                   pick_step(), ($urandom_range(0, 2) == 0)
                                   ? 16'($urandom_range(0, 2000)) : 16'($urandom));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if (p == 3 || p == 7) hold_req = 1'b1;
            run_left = 0;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    mode     = (p == 0 && n == 0) ? MODE_PUSH_UP : $urandom_range(0, 4);
                    run_left = (mode == MODE_PUSH_UP || mode == MODE_PUSH_DOWN)
                             ? $urandom_range(20, 110) : $urandom_range(5, 30);
                    if (p == 0 && n == 0) run_left = 100;
                    anchor = 16'($urandom);
                end
                run_left--;
                case (mode)
                    MODE_PUSH_UP: begin
                        w.setpoint = 16'($urandom_range(16384, 32767));
                        w.measured = 16'(-int'($urandom_range(0, 32768)));
                    end
                    MODE_PUSH_DOWN: begin
                        w.measured = 16'($urandom_range(16384, 32767));
                        w.setpoint = 16'(-int'($urandom_range(0, 32768)));
                    end
                    MODE_TRACK: begin
                        w.setpoint = anchor;
                        w.measured = anchor + 16'(int'($urandom_range(0, 128)) - 64);
                    end
                    MODE_CORNER: begin
                        w.setpoint = corner_vals[$urandom_range(0, 4)];
                        w.measured = corner_vals[$urandom_range(0, 4)];
                    end
                    default: begin
                        w.setpoint = 16'($urandom);
                        w.measured = 16'($urandom);
                    end
                endcase
                send_sample(w.measured, w.setpoint, quiet ? 0 : idle_pick());
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pcs_pkg.sv
rtl/core/pcs_datapath.sv
rtl/core/pid_controller_saturating_unit.sv
dv/tb.sv
